@@ hdl/cave_pkg.sv @@
// Shared types, constants and the cell rule for the cave automaton generation step.
// Used by cave_cell, cave_rsp_fifo and cave_automaton_generation_step.
package cave_pkg;

   // Grid geometry: bus width and the number of live columns
   localparam int CAVE_BUS_W = 64;
   localparam int CAVE_COLS  = 64;

   // Threshold registers
   localparam int           CAVE_THR_W       = 4;
   localparam logic [3:0]   CAVE_BIRTH_RST   = 4'd5;
   localparam logic [3:0]   CAVE_SURVIVE_RST = 4'd4;

   typedef enum logic [0:0] {
      CAVE_REG_BIRTH   = 1'b0,
      CAVE_REG_SURVIVE = 1'b1
   } cave_reg_type;

   // Result queue geometry
   localparam int CAVE_FIFO_DEPTH = 4;
   localparam int CAVE_PTR_W      = $clog2(CAVE_FIFO_DEPTH);
   localparam int CAVE_CNT_W      = $clog2(CAVE_FIFO_DEPTH + 1);

   // One queued result row
   typedef struct packed {
      logic [CAVE_BUS_W-1:0] row;
      logic                  last;
   } cave_entry_type;

   // Control broadcast to every cell
   typedef struct packed {
      logic                  load;       // input transfer this cycle
      logic                  final_row;  // transferred row is the bottom row
      logic                  mid_valid;  // a middle row is held
      logic [CAVE_THR_W-1:0] birth;
      logic [CAVE_THR_W-1:0] survive;
   } cave_ctl_type;

   // Next state of one cell from three 3-bit windows (bit 0 is the left column)
   function automatic logic cave_next(
      input logic [2:0]            above,
      input logic [2:0]            here,
      input logic [2:0]            below,
      input logic [CAVE_THR_W-1:0] birth,
      input logic [CAVE_THR_W-1:0] survive
   );
      logic [3:0] count;
      count = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
            + 4'(here[0])  + 4'(here[2])
            + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
      return here[1] ? (count >= survive) : (count >= birth);
   endfunction

endpackage

@@ hdl/cave_automaton_generation_step.sv @@
// Top level of the cave automaton generation step: a row of column cells and a result queue.
// Depends on cave_pkg, cave_cell and cave_rsp_fifo.
//
//  Channel  Ports                         Payload
//  req      req_tvalid/tready/tdata/tlast tdata: row_in[63:0]; tlast: is_final_row
//  rsp      rsp_tvalid/tready/tdata/tlast tdata: row_out[63:0]; tlast: is_grid_end
//  csr      csr_we/csr_addr/csr_wdata     0: birth_threshold, 1: survive_threshold
//
//  One row per cycle is taken while req_tready is high; each cell column evaluates its neighbourhood in that cycle.
//  A result row is written into the result queue when the row that completes it is taken.
//  The bottom row pushes up to two rows into a four-entry queue; req_tready drops
//  only while fewer than two queue slots are free.
//  Reset (synchronous) restores the border rows and the default thresholds.
module cave_automaton_generation_step
   import cave_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CAVE_BUS_W-1:0] req_tdata,   // [63:0] row_in
   input  logic                  req_tlast,   // is_final_row
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CAVE_BUS_W-1:0] rsp_tdata,   // [63:0] row_out
   output logic                  rsp_tlast,   // is_grid_end
   input  logic                  csr_we,
   input  logic [0:0]            csr_addr,
   input  logic [CAVE_THR_W-1:0] csr_wdata
);

   logic [CAVE_THR_W-1:0] birth_ff, birth_in;
   logic [CAVE_THR_W-1:0] survive_ff, survive_in;
   logic                  mid_valid_ff, mid_valid_in;
   logic                  accept;
   logic                  room2;
   cave_ctl_type          ctl;

   logic [CAVE_COLS-1:0]  upper_vec, middle_vec, res_mid_vec, res_fin_vec, row_vec;
   logic [CAVE_COLS+1:0]  upper_pad, middle_pad, row_pad;

   logic [1:0]            wr_cnt;
   cave_entry_type        wr_a, wr_b, rd_data;

   // Threshold registers
   always_comb begin
      birth_in   = birth_ff;
      survive_in = survive_ff;
      if (csr_we) begin
         case (cave_reg_type'(csr_addr))
            CAVE_REG_BIRTH:   birth_in   = csr_wdata;
            CAVE_REG_SURVIVE: survive_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         birth_ff   <= CAVE_BIRTH_RST;
         survive_ff <= CAVE_SURVIVE_RST;
      end else begin
         birth_ff   <= birth_in;
         survive_ff <= survive_in;
      end
   end

   // Input handshake and held-row flag
   assign req_tready = room2;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      mid_valid_in = mid_valid_ff;
      if (accept) begin
         mid_valid_in = ~req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_comb begin
      ctl.load      = accept;
      ctl.final_row = req_tlast;
      ctl.mid_valid = mid_valid_ff;
      ctl.birth     = birth_ff;
      ctl.survive   = survive_ff;
   end

   // Border columns count as alive
   assign row_vec    = req_tdata[CAVE_COLS-1:0];
   assign upper_pad  = {1'b1, upper_vec, 1'b1};
   assign middle_pad = {1'b1, middle_vec, 1'b1};
   assign row_pad    = {1'b1, row_vec, 1'b1};

   // Chain of column cells, each seeing its left and right neighbours
   for (genvar i = 0; i < CAVE_COLS; i++) begin : g_col
      cave_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .upper3     (upper_pad[i+2:i]),
         .middle3    (middle_pad[i+2:i]),
         .row3       (row_pad[i+2:i]),
         .upper_bit  (upper_vec[i]),
         .middle_bit (middle_vec[i]),
         .res_mid    (res_mid_vec[i]),
         .res_fin    (res_fin_vec[i])
      );
   end

   // Result rows in order: held middle row first, then the bottom row
   always_comb begin
      wr_a.row  = CAVE_BUS_W'(res_mid_vec);
      wr_a.last = 1'b0;
      wr_b.row  = CAVE_BUS_W'(res_fin_vec);
      wr_b.last = 1'b1;
      wr_cnt    = 2'd0;
      if (accept) begin
         if (mid_valid_ff) begin
            wr_cnt = req_tlast ? 2'd2 : 2'd1;
         end else if (req_tlast) begin
            wr_a   = wr_b;
            wr_cnt = 2'd1;
         end
      end
   end

   cave_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_cnt   (wr_cnt),
      .wr_a     (wr_a),
      .wr_b     (wr_b),
      .room2    (room2),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (rd_data)
   );

   assign rsp_tdata = rd_data.row;
   assign rsp_tlast = rd_data.last;

endmodule

@@ hdl/cave_cell.sv @@
// One column of the automaton: holds the upper and middle row bits for its column.
// Depends on cave_pkg for the control struct and the cell rule.
module cave_cell
   import cave_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cave_ctl_type ctl,
   input  logic [2:0]   upper3,   // upper row: left, own, right
   input  logic [2:0]   middle3,  // middle row: left, own, right
   input  logic [2:0]   row3,     // incoming row: left, own, right
   output logic         upper_bit,
   output logic         middle_bit,
   output logic         res_mid,  // next generation of the held middle row
   output logic         res_fin   // next generation of the incoming bottom row
);

   logic upper_ff, upper_in;
   logic middle_ff, middle_in;
   logic [2:0] top3;

   // Evaluate both candidate results; the bottom row sees a live border below
   always_comb begin
      top3    = ctl.mid_valid ? middle3 : upper3;
      res_mid = cave_next(upper3, middle3, row3, ctl.birth, ctl.survive);
      res_fin = cave_next(top3, row3, 3'b111, ctl.birth, ctl.survive);
   end

   // Column state: shift rows down on a transfer, restore the border rows at grid end
   always_comb begin
      upper_in  = upper_ff;
      middle_in = middle_ff;
      if (ctl.load) begin
         if (ctl.final_row) begin
            upper_in  = 1'b1;
            middle_in = 1'b0;
         end else begin
            if (ctl.mid_valid) begin
               upper_in = middle_ff;
            end
            middle_in = row3[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= 1'b1;
         middle_ff <= 1'b0;
      end else begin
         upper_ff  <= upper_in;
         middle_ff <= middle_in;
      end
   end

   assign upper_bit  = upper_ff;
   assign middle_bit = middle_ff;

endmodule

@@ hdl/cave_rsp_fifo.sv @@
// Result queue: takes up to two rows per cycle, hands out one per transfer.
// Depends on cave_pkg for the entry type and queue geometry.
module cave_rsp_fifo
   import cave_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     wr_cnt,    // rows pushed this cycle: 0, 1 or 2
   input  cave_entry_type wr_a,
   input  cave_entry_type wr_b,
   output logic           room2,     // space for two rows
   output logic           rd_valid,
   input  logic           rd_ready,
   output cave_entry_type rd_data
);

   cave_entry_type              mem_ff [CAVE_FIFO_DEPTH];
   logic [CAVE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [CAVE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CAVE_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CAVE_PTR_W-1:0]       wr_ptr_b;
   logic                        pop;

   assign wr_ptr_b = wr_ptr_ff + CAVE_PTR_W'(1);
   assign pop      = rd_valid & rd_ready;
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign room2    = (cnt_ff <= CAVE_CNT_W'(CAVE_FIFO_DEPTH - 2));

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + CAVE_PTR_W'(wr_cnt);
      rd_ptr_in = rd_ptr_ff + CAVE_PTR_W'(pop);
      cnt_in    = cnt_ff + CAVE_CNT_W'(wr_cnt) - CAVE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (wr_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr_a;
      end
      if (wr_cnt == 2'd2) begin
         mem_ff[wr_ptr_b] <= wr_b;
      end
   end

endmodule

@@ hdl/cave_chk.sv @@
// Port-level checks for the cave automaton generation step, bound to the top level.
// Depends on cave_pkg for the bus width.
module cave_chk
   import cave_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [CAVE_BUS_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // Nothing is offered on the first edge out of reset
   a_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result offered right after reset");

   // A bottom row always yields at least one result row
   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("bottom row transfer produced no result");

   // Input back-pressure only arises from queued results
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind cave_automaton_generation_step cave_chk u_cave_chk (.*);

@@ verif/cave_row_checker.sv @@
`timescale 1ns / 100ps
// Checker for the cave automaton generation step: watches the row, result and CSR ports,
// predicts every result row and compares it on transfer. Depends on cave_pkg.
module cave_row_checker
   import cave_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [CAVE_BUS_W-1:0] req_tdata,   // [63:0] row_in
   input  logic                  req_tlast,   // is_final_row
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [CAVE_BUS_W-1:0] rsp_tdata,   // [63:0] row_out
   input  logic                  rsp_tlast,   // is_grid_end
   input  logic                  csr_we,
   input  logic [0:0]            csr_addr,
   input  logic [CAVE_THR_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding,
   output int                    rows_checked
);

   // Live columns set, unused columns clear; also the border row above and below the grid
   localparam logic [CAVE_BUS_W-1:0] BORDER_ROW = {CAVE_BUS_W{1'b1}} >> (CAVE_BUS_W - CAVE_COLS);

   typedef struct packed {
      logic [CAVE_BUS_W-1:0] row;
      logic                  last;
   } gen_row_type;

   gen_row_type expected_rows[$];

   // Own copy of the thresholds and the row window
   logic [CAVE_THR_W-1:0] birth_thr;
   logic [CAVE_THR_W-1:0] survive_thr;
   logic [CAVE_BUS_W-1:0] upper_row;
   logic [CAVE_BUS_W-1:0] middle_row;
   logic                  middle_held;
   int                    fail_total = 0;
   int                    n_checked = 0;

   // Next generation of the middle row; positions off the grid count as alive
   function automatic logic [CAVE_BUS_W-1:0] evolve_row(
      input logic [CAVE_BUS_W-1:0] above,
      input logic [CAVE_BUS_W-1:0] here,
      input logic [CAVE_BUS_W-1:0] below
   );
      logic [CAVE_COLS+1:0]  ax;
      logic [CAVE_COLS+1:0]  hx;
      logic [CAVE_COLS+1:0]  bx;
      logic [CAVE_BUS_W-1:0] nxt;
      logic [3:0]            live;
      // bit 0 is the left border, bit c+1 is column c
      ax  = {1'b1, above[CAVE_COLS-1:0], 1'b1};
      hx  = {1'b1, here[CAVE_COLS-1:0], 1'b1};
      bx  = {1'b1, below[CAVE_COLS-1:0], 1'b1};
      nxt = '0;
      for (int c = 0; c < CAVE_COLS; c++) begin
         live = 4'(ax[c]) + 4'(ax[c+1]) + 4'(ax[c+2])
              + 4'(hx[c]) + 4'(hx[c+2])
              + 4'(bx[c]) + 4'(bx[c+1]) + 4'(bx[c+2]);
         nxt[c] = hx[c+1] ? (live >= survive_thr) : (live >= birth_thr);
      end
      return nxt;
   endfunction

   task automatic report(input string what, input logic [CAVE_BUS_W-1:0] want,
                         input logic [CAVE_BUS_W-1:0] got);
      fail_total++;
      if (fail_total <= 10) begin
         $display("checker: %0t %s: expected %h, got %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      gen_row_type           want;
      logic [CAVE_BUS_W-1:0] row;
      if (reset) begin
         birth_thr   = CAVE_BIRTH_RST;
         survive_thr = CAVE_SURVIVE_RST;
         upper_row   = BORDER_ROW;
         middle_row  = '0;
         middle_held = 1'b0;
         expected_rows.delete();
      end else begin
         // Threshold writes
         if (csr_we) begin
            case (cave_reg_type'(csr_addr))
               CAVE_REG_BIRTH:   birth_thr = csr_wdata;
               CAVE_REG_SURVIVE: survive_thr = csr_wdata;
               default: ;
            endcase
         end

         // Result transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rows.size() == 0) begin
               report("result row with nothing expected", '0, rsp_tdata);
            end else begin
               want = expected_rows.pop_front();
               n_checked++;
               if (rsp_tdata !== want.row) begin
                  report("row_out mismatch", want.row, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  report("is_grid_end mismatch", CAVE_BUS_W'(want.last), CAVE_BUS_W'(rsp_tlast));
               end
            end
         end

         // Row transfer: complete the held row, then close the grid on the bottom row
         if (req_tvalid && req_tready) begin
            row = req_tdata & BORDER_ROW;
            if (middle_held) begin
               expected_rows.push_back('{row: evolve_row(upper_row, middle_row, row), last: 1'b0});
               upper_row = middle_row;
            end
            middle_row  = row;
            middle_held = 1'b1;
            if (req_tlast) begin
               expected_rows.push_back('{row: evolve_row(upper_row, middle_row, BORDER_ROW),
                                         last: 1'b1});
               upper_row   = BORDER_ROW;
               middle_row  = '0;
               middle_held = 1'b0;
            end
         end
      end
      mismatches   <= fail_total;
      outstanding  <= expected_rows.size();
      rows_checked <= n_checked;
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the cave automaton generation step: clock, reset, row stimulus,
// threshold sweep and verdict. Depends on cave_pkg, the block and cave_row_checker.
module tb_top;
   import cave_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_TARGET = 450;
   localparam int N_DIRECTED  = 17;
   localparam int N_PHASES    = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CAVE_BUS_W-1:0] req_tdata = '0;   // [63:0] row_in
   logic                  req_tlast = 1'b0; // is_final_row
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [CAVE_BUS_W-1:0] rsp_tdata;        // [63:0] row_out
   logic                  rsp_tlast;        // is_grid_end
   logic                  csr_we = 1'b0;
   logic [0:0]            csr_addr = CAVE_REG_BIRTH;
   logic [CAVE_THR_W-1:0] csr_wdata = '0;

   int mismatches;
   int outstanding;
   int rows_checked;
   int sender_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;
   int grids_sent = 0;
   int cycle_count = 0;

   // Threshold settings per phase: defaults, both extremes, unreachable values and mixes
   int birth_sweep[N_PHASES]   = '{5, 0, 15, 8, 9, 1, 3, 7};
   int survive_sweep[N_PHASES] = '{4, 0, 15, 8, 0, 9, 6, 2};

   cave_automaton_generation_step DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   cave_row_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .rows_checked (rows_checked)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles, %0d rows outstanding",
                  cycle_count, outstanding);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // One row transfer, with random idle cycles ahead of it
   task automatic send_row(input logic [CAVE_BUS_W-1:0] row, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (last) begin
         grids_sent++;
      end
   endtask

   // Hold the sender until every predicted row has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   // Both thresholds on consecutive edges; only called while idle
   task automatic set_thresholds(input int birth, input int survive);
      csr_we    <= 1'b1;
      csr_addr  <= CAVE_REG_BIRTH;
      csr_wdata <= CAVE_THR_W'(birth);
      @(posedge clock);
      csr_addr  <= CAVE_REG_SURVIVE;
      csr_wdata <= CAVE_THR_W'(survive);
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Mix of plain, dense, sparse and nearly full rows so neighbour counts spread out
   function automatic logic [CAVE_BUS_W-1:0] random_row();
      logic [CAVE_BUS_W-1:0] a;
      logic [CAVE_BUS_W-1:0] b;
      logic [CAVE_BUS_W-1:0] c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(5))
         0, 1: return a;
         2:    return a | b;
         3:    return a & b;
         4:    return ~(a & b & c);
         default: return ($urandom_range(1) != 0) ? '1 : (a & b & c);
      endcase
   endfunction

   initial begin
      int height;
      int grid_no;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed grids at the reset thresholds
      send_row('1, 1'b1);                                  // single-row grid, all alive
      send_row('0, 1'b1);                                  // single-row grid, all dead
      send_row(64'h8000_0000_0000_0001, 1'b1);             // edge columns only
      send_row('0, 1'b0);
      send_row('0, 1'b1);
      send_row('1, 1'b0);
      send_row('0, 1'b1);
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_row(64'h5555_5555_5555_5555, 1'b0);
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      send_row('0, 1'b0);
      send_row(64'h0000_0001_0000_0000, 1'b0);             // lone cell mid-row
      send_row('0, 1'b1);
      send_row(64'hFFFF_0000_FFFF_0000, 1'b0);
      send_row(64'h0000_FFFF_0000_FFFF, 1'b0);
      send_row(64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
      send_row(64'hF0F0_F0F0_F0F0_F0F0, 1'b1);

      // Random grids over the threshold sweep and the four idling patterns
      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         repeat (4) @(posedge clock);
         set_thresholds(birth_sweep[p], survive_sweep[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         grid_no = 0;
         while (items_sent < N_DIRECTED + (p + 1) * ((ITEM_TARGET - N_DIRECTED) / N_PHASES)) begin
            height = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
            for (int r = 0; r < height; r++) begin
               send_row(random_row(), r == height - 1);
            end
            grid_no++;
            // pause mid-phase until the result queue has emptied
            if (grid_no == 3) begin
               wait_idle();
            end
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("tb_top: %0d rows in %0d grids sent, %0d result rows checked",
               items_sent, grids_sent, rows_checked);
      $display("tb_top: %0d threshold settings incl. 0 and 15, four stall patterns",
               N_PHASES);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

@@ cave_automaton_generation_step.f @@
hdl/cave_pkg.sv
hdl/cave_cell.sv
hdl/cave_rsp_fifo.sv
hdl/cave_automaton_generation_step.sv
hdl/cave_chk.sv
verif/cave_row_checker.sv
verif/tb_top.sv
